// ----- sv/checksum_frame_receive_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checksum frame receive parser.
// Each macro takes a label, an antecedent and a consequent, and checks them
// on the rising edge of i_clk while reset is released.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVE_PARSER_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication.
`define CFRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfrp assertion failed");

// Next-cycle implication.
`define CFRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfrp assertion failed");

`endif

// ----- sv/cfrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrp_pkg
// Shared types, character codes and helpers for the frame receive parser.
// ----------------------------------------------------------------------------
package cfrp_pkg;

    // Default receive buffer depth and fixed field widths.
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int IDX_W            = 6;
    localparam int BYTE_W           = 8;

    // Operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // Framing characters.
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

    // Checksum stage codes.
    localparam logic [1:0] STG_PAYLOAD = 2'd0;
    localparam logic [1:0] STG_HIGH    = 2'd1;
    localparam logic [1:0] STG_LOW     = 2'd2;
    localparam logic [1:0] STG_DONE    = 2'd3;

    // One input word.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    // One result word.
    typedef struct packed {
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              frame_good;
        logic [IDX_W-1:0]  frame_length;
        logic              receiving;
        logic              done_held;
    } t_result;

    // Decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Upper-case hex digit decode: '0'-'9' and 'A'-'F' only.
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex h;
        logic [BYTE_W-1:0] d;
        h = '0;
        d = '0;
        if (c > 8'd47 && c < 8'd58) begin
            d     = c - 8'd48;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (c > 8'd64 && c < 8'd71) begin
            d     = c - 8'd55;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

endpackage

// ----- sv/checksum_frame_receive_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_receive_parser
// Receive parser for '$' payload '*' hex hex CR/LF frames with XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per cycle:
// i_op selects a received byte (i_rx_byte) or a software acknowledge that
// clears the held done flag. The output channel (o_out_valid / i_out_ready)
// returns exactly one result word per input word: a buffer store request
// (o_store_valid, o_store_index, o_store_byte), a frame_good pulse with the
// frame length, and the in-frame and done flags after that word.
// An accepted word sits in the input register while the parser forms its
// result, which loads the result register once that register has room.
// Throughput is one word per cycle while the receiver keeps i_out_ready high,
// set by the single parser pass that updates the frame state and loads the
// result register in the same cycle.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// frame state, count, XOR and received checksum.
// When the receiver stalls, the result register holds its word, the input
// register fills, and o_in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`include "checksum_frame_receive_parser_defines.svh"

module checksum_frame_receive_parser #(
    parameter int BUFFER_DEPTH = cfrp_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [cfrp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_store_valid,
    output logic [cfrp_pkg::IDX_W-1:0]     o_store_index,
    output logic [cfrp_pkg::BYTE_W-1:0]    o_store_byte,
    output logic                           o_frame_good,
    output logic [cfrp_pkg::IDX_W-1:0]     o_frame_length,
    output logic                           o_receiving,
    output logic                           o_done_held
);

    cfrp_pkg::t_item   in_item;
    cfrp_pkg::t_item   held_item;
    cfrp_pkg::t_result step_result;
    cfrp_pkg::t_result out_result;
    logic              held_valid;
    logic              out_space;
    logic              advance;

    assign in_item.op      = i_op;
    assign in_item.rx_byte = i_rx_byte;

    // A held word moves through the parser whenever the result register has room.
    assign advance = held_valid && out_space;

    cfrp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_in_ready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    cfrp_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (held_item),
        .o_result (step_result)
    );

    cfrp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .i_ready  (i_out_ready),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    // Result fields to ports.
    assign o_store_valid  = out_result.store_valid;
    assign o_store_index  = out_result.store_index;
    assign o_store_byte   = out_result.store_byte;
    assign o_frame_good   = out_result.frame_good;
    assign o_frame_length = out_result.frame_length;
    assign o_receiving    = out_result.receiving;
    assign o_done_held    = out_result.done_held;

    // A good frame closes the frame and holds done; it never stores a byte.
    `CFRP_ASSERT_IMP(a_good_closes, o_out_valid && o_frame_good, !o_store_valid && o_done_held && !o_receiving)

    // A store only happens inside an open frame with done clear.
    `CFRP_ASSERT_IMP(a_store_in_frame, o_out_valid && o_store_valid, o_receiving && !o_done_held)

    // Full input register behind a stalled output blocks new words.
    `CFRP_ASSERT_IMP(a_stall_blocks, held_valid && o_out_valid && !i_out_ready, !o_in_ready)

    // A stalled result word stays in place.
    `CFRP_ASSERT_NXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(out_result))

endmodule

// ----- sv/cfrp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrp_in_stage
// Input register: captures one word per cycle while it has room and holds it
// until the parser advances.
// ----------------------------------------------------------------------------
module cfrp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cfrp_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output cfrp_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    cfrp_pkg::t_item r_item;

    // The register frees up whenever its word moves on to the parser.
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/cfrp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrp_parser
// Frame state and per-word decode: tracks the open frame, checksum stage,
// payload count and running XOR, and forms the result for each word.
// ----------------------------------------------------------------------------
module cfrp_parser #(
    parameter int BUFFER_DEPTH = cfrp_pkg::BUFFER_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  cfrp_pkg::t_item   i_item,
    output cfrp_pkg::t_result o_result
);

    localparam int IW      = cfrp_pkg::IDX_W;
    localparam int BW      = cfrp_pkg::BYTE_W;
    localparam int IDX_MAX = (1 << IW) - 1;
    localparam int CAP     = (BUFFER_DEPTH - 1 > IDX_MAX) ? IDX_MAX : BUFFER_DEPTH - 1;
    // One buffer slot stays free for the end mark.
    localparam logic [IW-1:0] CAP_CNT = IW'(CAP);

    logic          r_in_frame;
    logic          n_in_frame;
    logic          r_done;
    logic          n_done;
    logic [1:0]    r_stage;
    logic [1:0]    n_stage;
    logic [IW-1:0] r_count;
    logic [IW-1:0] n_count;
    logic [BW-1:0] r_xor;
    logic [BW-1:0] n_xor;
    logic [BW-1:0] r_check;
    logic [BW-1:0] n_check;

    cfrp_pkg::t_hex    hex;
    cfrp_pkg::t_result res;
    logic [BW-1:0]     b;
    logic              is_term;

    assign b       = i_item.rx_byte;
    assign hex     = cfrp_pkg::hex_decode(b);
    assign is_term = (b == cfrp_pkg::CH_CR) || (b == cfrp_pkg::CH_LF);

    // Next state and result for the word at the head of the input register.
    always_comb begin
        n_in_frame = r_in_frame;
        n_done     = r_done;
        n_stage    = r_stage;
        n_count    = r_count;
        n_xor      = r_xor;
        n_check    = r_check;
        res        = '0;

        if (i_item.op == cfrp_pkg::OP_ACK) begin
            n_done = 1'b0;
        end else if (!r_done && b != cfrp_pkg::CH_NUL) begin
            if (b == cfrp_pkg::CH_DOLLAR) begin
                // Start mark opens a fresh frame; the received check is kept.
                n_in_frame = 1'b1;
                n_stage    = cfrp_pkg::STG_PAYLOAD;
                n_count    = '0;
                n_xor      = '0;
            end else if (is_term) begin
                // A terminator only counts after both digits of a non-empty frame.
                if (r_count != '0 && r_in_frame && r_stage == cfrp_pkg::STG_DONE) begin
                    n_in_frame = 1'b0;
                    if (r_xor == r_check) begin
                        n_done           = 1'b1;
                        res.frame_good   = 1'b1;
                        res.frame_length = r_count;
                    end
                end
            end else if (b == cfrp_pkg::CH_STAR) begin
                n_stage = cfrp_pkg::STG_HIGH;
            end else if (r_in_frame) begin
                unique case (r_stage)
                    cfrp_pkg::STG_PAYLOAD: begin
                        if (r_count < CAP_CNT) begin
                            n_xor           = r_xor ^ b;
                            res.store_valid = 1'b1;
                            res.store_index = r_count;
                            res.store_byte  = b;
                            n_count         = r_count + 1'b1;
                        end else begin
                            // Buffer full: the byte is dropped and the frame aborts.
                            n_in_frame = 1'b0;
                        end
                    end
                    cfrp_pkg::STG_HIGH: begin
                        if (hex.ok) begin
                            n_check = {hex.val, 4'h0};
                        end else begin
                            n_in_frame = 1'b0;
                        end
                        n_stage = cfrp_pkg::STG_LOW;
                    end
                    cfrp_pkg::STG_LOW: begin
                        if (hex.ok) begin
                            n_check = {r_check[BW-1:4], hex.val};
                        end else begin
                            n_in_frame = 1'b0;
                        end
                        n_stage = cfrp_pkg::STG_DONE;
                    end
                    default: begin
                        // A byte after the digits that is not a terminator, start mark, star or NUL aborts.
                        n_in_frame = 1'b0;
                    end
                endcase
            end
        end

        res.receiving = n_in_frame;
        res.done_held = n_done;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_done     <= 1'b0;
            r_stage    <= cfrp_pkg::STG_PAYLOAD;
            r_count    <= '0;
            r_xor      <= '0;
            r_check    <= '0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_done     <= n_done;
            r_stage    <= n_stage;
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_check    <= n_check;
        end
    end

    assign o_result = res;

endmodule

// ----- sv/cfrp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrp_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module cfrp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cfrp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_space,
    output logic              o_valid,
    output cfrp_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    cfrp_pkg::t_result r_result;

    // A new word may load when the register is empty or drains this cycle.
    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
